### rtl/core/rppa_pkg.sv
package rppa_pkg;

    localparam int COUNT_BITS       = 16;
    localparam int SAMPLE_FRAC_BITS = 16;
    localparam int CHAN_BITS        = 8;
    localparam int NUM_CHANS        = 3;
    localparam int PIXEL_BITS       = 32;
    localparam int SAMPLE_BITS      = CHAN_BITS + SAMPLE_FRAC_BITS;

    // sample * 255 before and after dropping the fraction
    localparam int SCALE_PROD_BITS  = SAMPLE_BITS + CHAN_BITS;
    localparam int SCALED_BITS      = SCALE_PROD_BITS - SAMPLE_FRAC_BITS;
    // (n - 1) * old
    localparam int PROD_BITS        = COUNT_BITS + CHAN_BITS;
    localparam int NUM_BITS         = ((PROD_BITS > SCALED_BITS) ? PROD_BITS : SCALED_BITS) + 1;
    localparam int HI_BITS          = NUM_BITS - CHAN_BITS;

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = CHAN_BITS / DIV_STEPS_PER_STAGE;

    localparam logic [CHAN_BITS-1:0]       CHAN_MAX   = 8'hFF;
    localparam logic [CHAN_BITS-1:0]       ALPHA_FULL = 8'hFF;
    localparam logic [SCALE_PROD_BITS-1:0] CHAN_SCALE = SCALE_PROD_BITS'(255);

    typedef struct packed {
        logic [PIXEL_BITS-1:0]                   old_pixel;
        logic [NUM_CHANS-1:0][SAMPLE_BITS-1:0]   sample;
        logic [COUNT_BITS-1:0]                   n;
    } in_item_t;

    typedef struct packed {
        logic [PROD_BITS-1:0]   prod;
        logic [SCALED_BITS-1:0] scaled;
    } chan_mul_t;

    typedef struct packed {
        chan_mul_t [NUM_CHANS-1:0] ch;
        logic [COUNT_BITS-1:0]     n;
    } mul_item_t;

    // rem: partial remainder, bits: unshifted dividend bits on top, quotient below
    typedef struct packed {
        logic                  sat;
        logic [COUNT_BITS-1:0] rem;
        logic [CHAN_BITS-1:0]  bits;
    } chan_div_t;

    typedef struct packed {
        chan_div_t [NUM_CHANS-1:0] ch;
        logic [COUNT_BITS-1:0]     n;
    } div_item_t;

endpackage

### rtl/core/rppa_pix_in_if.sv
interface rppa_pix_in_if;
    import rppa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PIXEL_BITS-1:0]  old_pixel;
    logic [SAMPLE_BITS-1:0] sample_red;
    logic [SAMPLE_BITS-1:0] sample_green;
    logic [SAMPLE_BITS-1:0] sample_blue;
    logic [COUNT_BITS-1:0]  sample_number;

    modport source (output valid, old_pixel, sample_red, sample_green, sample_blue,
                    sample_number, input ready);
    modport sink   (input valid, old_pixel, sample_red, sample_green, sample_blue,
                    sample_number, output ready);
endinterface

### rtl/core/rppa_pix_out_if.sv
interface rppa_pix_out_if;
    import rppa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] new_pixel;

    modport source (output valid, new_pixel, input ready);
    modport sink   (input valid, new_pixel, output ready);
endinterface

### rtl/core/rppa_mul_stage.sv
// Stage 1: scale samples by 255 and form (n-1)*old per channel.
module rppa_mul_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rppa_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rppa_pkg::mul_item_t out_item
);
    import rppa_pkg::*;

    logic      valid_reg;
    mul_item_t item_reg;
    mul_item_t item_next;

    logic [COUNT_BITS-1:0]      n_eff;
    logic [COUNT_BITS-1:0]      n_m1;
    logic [SCALE_PROD_BITS-1:0] scale_prod [NUM_CHANS];

    always_comb
    begin
        n_eff = (in_item.n == '0) ? COUNT_BITS'(1) : in_item.n;
        n_m1  = n_eff - COUNT_BITS'(1);
        item_next.n = n_eff;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            scale_prod[c] = SCALE_PROD_BITS'(in_item.sample[c]) * CHAN_SCALE;
            item_next.ch[c].scaled = scale_prod[c][SCALE_PROD_BITS-1:SAMPLE_FRAC_BITS];
            item_next.ch[c].prod   = PROD_BITS'(n_m1)
                                   * PROD_BITS'(in_item.old_pixel[c*CHAN_BITS +: CHAN_BITS]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

### rtl/core/rppa_sum_stage.sv
// Stage 2: numerator sum, saturation check, divider setup.
module rppa_sum_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rppa_pkg::mul_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rppa_pkg::div_item_t out_item
);
    import rppa_pkg::*;

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    logic [NUM_BITS-1:0] num [NUM_CHANS];
    logic [HI_BITS-1:0]  hi  [NUM_CHANS];

    always_comb
    begin
        item_next.n = in_item.n;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            num[c] = NUM_BITS'(in_item.ch[c].prod) + NUM_BITS'(in_item.ch[c].scaled);
            hi[c]  = num[c][NUM_BITS-1:CHAN_BITS];
            // quotient of 256 or more saturates
            item_next.ch[c].sat  = (hi[c] >= HI_BITS'(in_item.n));
            item_next.ch[c].rem  = hi[c][COUNT_BITS-1:0];
            item_next.ch[c].bits = num[c][CHAN_BITS-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

### rtl/core/rppa_div_stage.sv
// Restoring division, DIV_STEPS_PER_STAGE quotient bits per stage.
module rppa_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rppa_pkg::div_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rppa_pkg::div_item_t out_item
);
    import rppa_pkg::*;

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    function automatic chan_div_t div_step(chan_div_t c, logic [COUNT_BITS-1:0] n);
        logic [COUNT_BITS:0] trial;
        logic                q;
        chan_div_t           r;
        trial = {c.rem, c.bits[CHAN_BITS-1]};
        q     = (trial >= {1'b0, n});
        r.sat = c.sat;
        r.rem = q ? COUNT_BITS'(trial - {1'b0, n}) : trial[COUNT_BITS-1:0];
        r.bits = {c.bits[CHAN_BITS-2:0], q};
        return r;
    endfunction

    always_comb
    begin
        item_next = in_item;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            for (int s = 0; s < DIV_STEPS_PER_STAGE; s++)
            begin
                item_next.ch[c] = div_step(item_next.ch[c], in_item.n);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

### rtl/core/rgb8_progressive_pixel_average_top.sv
// Progressive RGB8 pixel average: each transaction on pix_in folds one Q8.16 sample
// (scaled to floor(x*255)) into the old packed pixel as floor(((n-1)*old + s)/n)
// per channel, saturated to 255, and returns the repacked pixel with alpha 0xFF on
// pix_out. A sample number of 0 counts as 1. Throughput is one pixel per clock while
// pix_out is not stalled. The pipeline holds 2 + DIV_STAGES = 6 register stages: the
// multiply stage, the sum/saturation stage and the four divider stages of two
// quotient bits each. An accepted pixel moves through these registers in order,
// and the last divider register drives pix_out. Each stage has its own valid bit and a
// stalled output only backs up the stages behind it, so pix_in.ready stays high
// while any stage has room.
module rgb8_progressive_pixel_average_top (
    input  logic          clk,
    input  logic          rst_n,
    rppa_pix_in_if.sink   pix_in,
    rppa_pix_out_if.source pix_out
);
    import rppa_pkg::*;

    in_item_t  in_item;
    mul_item_t mul_item;
    logic      mul_valid;
    logic      mul_ready;

    // divider chain: index 0 is the sum stage output
    div_item_t div_item  [DIV_STAGES+1];
    logic      div_valid [DIV_STAGES+1];
    logic      div_ready [DIV_STAGES+1];

    div_item_t                 last;
    logic [CHAN_BITS-1:0]      chan_out [NUM_CHANS];

    always_comb
    begin
        in_item.old_pixel = pix_in.old_pixel;
        in_item.sample[0] = pix_in.sample_red;
        in_item.sample[1] = pix_in.sample_green;
        in_item.sample[2] = pix_in.sample_blue;
        in_item.n         = pix_in.sample_number;
    end

    rppa_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .in_item   (in_item),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_item  (mul_item)
    );

    rppa_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_item   (mul_item),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_item  (div_item[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        rppa_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_item   (div_item[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_item  (div_item[k+1])
        );
    end

    // last divider register is the output register
    assign last                  = div_item[DIV_STAGES];
    assign pix_out.valid         = div_valid[DIV_STAGES];
    assign div_ready[DIV_STAGES] = pix_out.ready;

    always_comb
    begin
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            chan_out[c] = last.ch[c].sat ? CHAN_MAX : last.ch[c].bits;
        end
    end

    assign pix_out.new_pixel = {ALPHA_FULL, chan_out[2], chan_out[1], chan_out[0]};

`ifndef NO_ASSERTIONS
    logic [DIV_STAGES+1:0] occ;
    logic                  in_acc;
    logic                  out_acc;

    always_comb
    begin
        occ[0] = mul_valid;
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            occ[k+1] = div_valid[k];
        end
    end

    assign in_acc  = pix_in.valid && pix_in.ready;
    assign out_acc = pix_out.valid && pix_out.ready;

    // no transaction lost or duplicated inside the pipeline
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(occ) ==
                 $past($countones(occ)) + int'($past(in_acc)) - int'($past(out_acc)))
        else $error("pipeline occupancy mismatch");

    // an empty first stage always takes a transaction
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !mul_valid |-> pix_in.ready)
        else $error("input stalled with first stage empty");

    // zero sample number is remapped to one before the divider
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> last.n != '0)
        else $error("zero divisor reached output");
`endif
endmodule
